// ===== rtl/core/stt_pkg.sv =====
// Shared types and constants for the system tick timer.
// Holds the operation and register select codes and the request and response beat layouts.
// No dependencies.
`timescale 1ns / 1ps

package stt_pkg;

   // Fixed field widths of the bus beats
   localparam int DATA_W    = 32;
   localparam int ELAPSED_W = 24;
   localparam int FUNC_W    = 2;
   localparam int SEL_W     = 2;

   // Control register bit positions
   localparam int CTRL_EN_BIT  = 0;
   localparam int CTRL_IE_BIT  = 1;
   localparam int CTRL_CLK_BIT = 2;
   localparam int CTRL_FLAG_BIT = 16;

   // Operation carried by one request beat
   typedef enum logic [FUNC_W-1:0] {
      FUNC_CORE_TICK = 2'd0,
      FUNC_REF_TICK  = 2'd1,
      FUNC_READ      = 2'd2,
      FUNC_WRITE     = 2'd3
   } func_type;

   // Register addressed by a bus access
   typedef enum logic [SEL_W-1:0] {
      REG_CONTROL = 2'd0,
      REG_RELOAD  = 2'd1,
      REG_CURRENT = 2'd2
   } reg_sel_type;

   typedef struct packed {
      logic [FUNC_W-1:0] func;
      logic [SEL_W-1:0]  reg_select;
      logic [DATA_W-1:0] write_data;
   } req_item_type;

   typedef struct packed {
      logic [DATA_W-1:0]    read_data;
      logic                 irq_pulse;
      logic [ELAPSED_W-1:0] elapsed_ticks;
   } rsp_item_type;

endpackage

// ===== rtl/core/stt_req_if.sv =====
// Request channel of the system tick timer: valid/ready handshake with one request beat.
// Depends on stt_pkg for the field widths.
`timescale 1ns / 1ps

interface stt_req_if
   import stt_pkg::*;
();
   logic              valid;
   logic              ready;
   logic [FUNC_W-1:0] func;
   logic [SEL_W-1:0]  reg_select;
   logic [DATA_W-1:0] write_data;

   modport source (output valid, output func, output reg_select, output write_data,
                   input ready);
   modport sink   (input valid, input func, input reg_select, input write_data,
                   output ready);
endinterface

// ===== rtl/core/stt_rsp_if.sv =====
// Response channel of the system tick timer: valid/ready handshake with one response beat.
// Depends on stt_pkg for the field widths.
`timescale 1ns / 1ps

interface stt_rsp_if
   import stt_pkg::*;
();
   logic                 valid;
   logic                 ready;
   logic [DATA_W-1:0]    read_data;
   logic                 irq_pulse;
   logic [ELAPSED_W-1:0] elapsed_ticks;

   modport source (output valid, output read_data, output irq_pulse, output elapsed_ticks,
                   input ready);
   modport sink   (input valid, input read_data, input irq_pulse, input elapsed_ticks,
                   output ready);
endinterface

// ===== rtl/core/stt_timer_core.sv =====
// Timer state and per-beat update: enables, count flag, reload and current value.
// Computes the response for one request beat and commits the new state on step.
// Depends on stt_pkg.
`timescale 1ns / 1ps

module stt_timer_core
   import stt_pkg::*;
#(
   parameter int COUNTER_WIDTH = 24
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         step,
   input  req_item_type item,
   input  logic         single_shot,
   output rsp_item_type result
);

   logic                     en_ff, en_in;
   logic                     ie_ff, ie_in;
   logic                     clk_sel_ff, clk_sel_in;
   logic                     flag_ff, flag_in;
   logic [COUNTER_WIDTH-1:0] reload_ff, reload_in;
   logic [COUNTER_WIDTH-1:0] cur_ff, cur_in;

   logic                     from_core;
   logic [COUNTER_WIDTH-1:0] cnt_dec;
   logic [COUNTER_WIDTH-1:0] elapsed_diff;
   logic [DATA_W-1:0]        rd_data;
   logic                     irq;

   assign from_core = (func_type'(item.func) == FUNC_CORE_TICK);
   assign cnt_dec   = cur_ff - COUNTER_WIDTH'(1);

   // Next state and read data for the beat in the input register
   always_comb begin
      en_in      = en_ff;
      ie_in      = ie_ff;
      clk_sel_in = clk_sel_ff;
      flag_in    = flag_ff;
      reload_in  = reload_ff;
      cur_in     = cur_ff;
      rd_data    = '0;
      irq        = 1'b0;
      case (func_type'(item.func))
         FUNC_CORE_TICK, FUNC_REF_TICK: begin
            // A tick counts only when enabled and from the selected source.
            if (en_ff && (from_core == clk_sel_ff)) begin
               if (cur_ff == '0) begin
                  cur_in = reload_ff;
               end else begin
                  cur_in = cnt_dec;
                  if (cnt_dec == '0) begin
                     flag_in = 1'b1;
                     if (ie_ff) begin
                        irq = 1'b1;
                        // One-shot mode stops and clears the timer when it fires.
                        if (single_shot) begin
                           en_in     = 1'b0;
                           ie_in     = 1'b0;
                           reload_in = '0;
                           cur_in    = '0;
                        end
                     end
                  end
               end
            end
         end
         FUNC_READ: begin
            case (reg_sel_type'(item.reg_select))
               REG_CONTROL: begin
                  rd_data[CTRL_EN_BIT]   = en_ff;
                  rd_data[CTRL_IE_BIT]   = ie_ff;
                  rd_data[CTRL_CLK_BIT]  = clk_sel_ff;
                  rd_data[CTRL_FLAG_BIT] = flag_ff;
                  flag_in                = 1'b0;
               end
               REG_RELOAD:  rd_data = DATA_W'(reload_ff);
               REG_CURRENT: rd_data = DATA_W'(cur_ff);
               default:     rd_data = '0;
            endcase
         end
         FUNC_WRITE: begin
            case (reg_sel_type'(item.reg_select))
               REG_CONTROL: begin
                  en_in      = item.write_data[CTRL_EN_BIT];
                  ie_in      = item.write_data[CTRL_IE_BIT];
                  clk_sel_in = item.write_data[CTRL_CLK_BIT];
               end
               REG_RELOAD: reload_in = item.write_data[COUNTER_WIDTH-1:0];
               REG_CURRENT: begin
                  cur_in  = '0;
                  flag_in = 1'b0;
               end
               default: ;
            endcase
         end
         default: ;
      endcase
   end

   // Elapsed ticks are taken after this beat's update.
   assign elapsed_diff         = reload_in - cur_in;
   assign result.read_data     = rd_data;
   assign result.irq_pulse     = irq;
   assign result.elapsed_ticks = ELAPSED_W'(elapsed_diff);

   // Timer state, committed once per processed beat
   always_ff @(posedge clock) begin
      if (reset) begin
         en_ff      <= 1'b0;
         ie_ff      <= 1'b0;
         clk_sel_ff <= 1'b0;
         flag_ff    <= 1'b0;
         reload_ff  <= '0;
         cur_ff     <= '0;
      end else if (step) begin
         en_ff      <= en_in;
         ie_ff      <= ie_in;
         clk_sel_ff <= clk_sel_in;
         flag_ff    <= flag_in;
         reload_ff  <= reload_in;
         cur_ff     <= cur_in;
      end
   end

`ifndef SYNTHESIS
   a_irq_sets_flag: assert property (@(posedge clock) disable iff (reset)
      step && result.irq_pulse |=> flag_ff)
      else $error("interrupt fired without setting the count flag");

   a_one_shot_clears: assert property (@(posedge clock) disable iff (reset)
      step && result.irq_pulse && single_shot |=> !en_ff && !ie_ff &&
      (reload_ff == '0) && (cur_ff == '0))
      else $error("one-shot firing did not stop and clear the timer");

   a_ctrl_read_clears_flag: assert property (@(posedge clock) disable iff (reset)
      step && (func_type'(item.func) == FUNC_READ) &&
      (reg_sel_type'(item.reg_select) == REG_CONTROL) |=> !flag_ff)
      else $error("control read did not clear the count flag");

   a_hold_without_step: assert property (@(posedge clock) disable iff (reset)
      !step |=> $stable(cur_ff) && $stable(reload_ff) && $stable(flag_ff))
      else $error("timer state changed without a processed beat");
`endif

endmodule

// ===== rtl/core/system_tick_timer.sv =====
// System tick timer top level: request register, timer core, response register.
// A request beat is registered on accept; its response is registered when it advances.
// Throughput: one beat per cycle while rsp_if.ready holds; state update is combinational.
// Reset (synchronous): clears enables, flag, reload and current value; one-shot mode is set.
// Depends on stt_pkg, stt_req_if, stt_rsp_if and stt_timer_core.
`timescale 1ns / 1ps

module system_tick_timer
   import stt_pkg::*;
#(
   parameter int COUNTER_WIDTH = 24
) (
   input  logic       clock,
   input  logic       reset,
   stt_req_if.sink    req_if,
   stt_rsp_if.source  rsp_if,
   input  logic       csr_wr_en,
   input  logic       csr_wr_data
);

   logic         in_valid_ff, in_valid_in;
   req_item_type in_item_ff;
   logic         out_valid_ff, out_valid_in;
   rsp_item_type out_item_ff;
   logic         single_shot_ff;
   logic         advance;
   logic         req_accept;
   rsp_item_type core_result;

   // Handshake: the held beat moves on when the response register is free or drained.
   assign advance       = in_valid_ff && (!out_valid_ff || rsp_if.ready);
   assign req_if.ready  = !in_valid_ff || advance;
   assign req_accept    = req_if.valid && req_if.ready;
   assign in_valid_in   = req_accept ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
   assign out_valid_in  = advance ? 1'b1 : (rsp_if.ready ? 1'b0 : out_valid_ff);

   stt_timer_core #(
      .COUNTER_WIDTH(COUNTER_WIDTH)
   ) u_core (
      .clock       (clock),
      .reset       (reset),
      .step        (advance),
      .item        (in_item_ff),
      .single_shot (single_shot_ff),
      .result      (core_result)
   );

   // Valid flags and the mode register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff    <= 1'b0;
         out_valid_ff   <= 1'b0;
         single_shot_ff <= 1'b1;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (csr_wr_en) begin
            single_shot_ff <= csr_wr_data;
         end
      end
   end

   // Beat payload registers
   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_item_ff.func       <= req_if.func;
         in_item_ff.reg_select <= req_if.reg_select;
         in_item_ff.write_data <= req_if.write_data;
      end
      if (advance) begin
         out_item_ff <= core_result;
      end
   end

   assign rsp_if.valid         = out_valid_ff;
   assign rsp_if.read_data     = out_item_ff.read_data;
   assign rsp_if.irq_pulse     = out_item_ff.irq_pulse;
   assign rsp_if.elapsed_ticks = out_item_ff.elapsed_ticks;

endmodule

// ===== bench/tb_system_tick_timer.sv =====
// Self-checking testbench for system_tick_timer: directed and random bus reads, writes and ticks.
// A beat-level predictor of the timer checks every response beat field by field.
// Depends on stt_pkg, stt_req_if, stt_rsp_if and system_tick_timer.
`timescale 1ns / 1ps

module tb_system_tick_timer;
   import stt_pkg::*;

   localparam int COUNT_W = 24;
   localparam int STALL_LIMIT = 2000;
   localparam int SETTLE_CYCLES = 6;
   localparam int HOLD_CYCLES = 60;
   localparam int HOLD_AFTER_BEATS = 150;
   localparam int PHASE_ITEMS = 280;
   localparam logic [SEL_W-1:0] REG_UNUSED = 2'd3;

   logic clock;
   logic reset;
   logic csr_wr_en;
   logic csr_wr_data;

   stt_req_if req_ch ();
   stt_rsp_if rsp_ch ();

   system_tick_timer #(
      .COUNTER_WIDTH(COUNT_W)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_if(req_ch.sink),
      .rsp_if(rsp_ch.source),
      .csr_wr_en(csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   // Predicted timer state.
   logic               tmr_enable = 1'b0;
   logic               tmr_irq_en = 1'b0;
   logic               tmr_core_clk = 1'b0;
   logic               tmr_flag = 1'b0;
   logic               tmr_one_shot;
   logic [COUNT_W-1:0] tmr_reload = '0;
   logic [COUNT_W-1:0] tmr_count = '0;

   req_item_type bus_requests[$];
   rsp_item_type timer_outcomes[$];
   req_item_type offered;
   rsp_item_type oldest;

   int idle_pct;
   int gap_left;
   int stall_left;
   int hold_left;
   bit hold_done;
   int req_beats = 0;
   int errors = 0;
   int quiet_cycles = 0;
   int phase_count;

   // One tick from the given source; returns the interrupt pulse.
   function automatic logic timer_tick(logic from_core);
      if (!tmr_enable || from_core != tmr_core_clk) return 1'b0;
      if (tmr_count == '0) begin
         tmr_count = tmr_reload;
         return 1'b0;
      end
      tmr_count = tmr_count - 1'b1;
      if (tmr_count != '0) return 1'b0;
      tmr_flag = 1'b1;
      if (!tmr_irq_en) return 1'b0;
      // The one-shot handler stops the timer and clears its values.
      if (tmr_one_shot) begin
         tmr_enable = 1'b0;
         tmr_irq_en = 1'b0;
         tmr_reload = '0;
         tmr_count = '0;
      end
      return 1'b1;
   endfunction

   // Applies one request beat to the predicted state and returns its response beat.
   function automatic rsp_item_type advance_timer(req_item_type rq);
      rsp_item_type       rs;
      logic [COUNT_W-1:0] diff;
      rs = '0;
      case (rq.func)
         FUNC_CORE_TICK: rs.irq_pulse = timer_tick(1'b1);
         FUNC_REF_TICK:  rs.irq_pulse = timer_tick(1'b0);
         FUNC_READ: begin
            case (rq.reg_select)
               REG_CONTROL: begin
                  rs.read_data[CTRL_EN_BIT] = tmr_enable;
                  rs.read_data[CTRL_IE_BIT] = tmr_irq_en;
                  rs.read_data[CTRL_CLK_BIT] = tmr_core_clk;
                  rs.read_data[CTRL_FLAG_BIT] = tmr_flag;
                  tmr_flag = 1'b0;
               end
               REG_RELOAD:  rs.read_data = DATA_W'(tmr_reload);
               REG_CURRENT: rs.read_data = DATA_W'(tmr_count);
               default: ;
            endcase
         end
         default: begin
            case (rq.reg_select)
               REG_CONTROL: begin
                  tmr_enable = rq.write_data[CTRL_EN_BIT];
                  tmr_irq_en = rq.write_data[CTRL_IE_BIT];
                  tmr_core_clk = rq.write_data[CTRL_CLK_BIT];
               end
               REG_RELOAD: tmr_reload = rq.write_data[COUNT_W-1:0];
               REG_CURRENT: begin
                  tmr_count = '0;
                  tmr_flag = 1'b0;
               end
               default: ;
            endcase
         end
      endcase
      diff = tmr_reload - tmr_count;
      rs.elapsed_ticks = diff[ELAPSED_W-1:0];
      return rs;
   endfunction

   function automatic void push_req(func_type f, logic [SEL_W-1:0] sel,
                                    logic [DATA_W-1:0] d);
      req_item_type rq;
      rq.func = f;
      rq.reg_select = sel;
      rq.write_data = d;
      bus_requests.push_back(rq);
   endfunction

   // Clock generation.
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Request driver: presents queued beats, with random gaps between them.
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
         req_ch.func <= FUNC_READ;
         req_ch.reg_select <= REG_CONTROL;
         req_ch.write_data <= '0;
         gap_left <= 0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            timer_outcomes.push_back(advance_timer(offered));
            req_beats <= req_beats + 1;
         end
         if (!req_ch.valid || req_ch.ready) begin
            if (gap_left != 0) begin
               req_ch.valid <= 1'b0;
               gap_left <= gap_left - 1;
            end else if (bus_requests.size() != 0 && $urandom_range(0, 99) < idle_pct) begin
               req_ch.valid <= 1'b0;
               gap_left <= $urandom_range(0, 6);
            end else if (bus_requests.size() != 0) begin
               offered = bus_requests.pop_front();
               req_ch.valid <= 1'b1;
               req_ch.func <= offered.func;
               req_ch.reg_select <= offered.reg_select;
               req_ch.write_data <= offered.write_data;
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // Response ready: random stalls, plus one long hold-off so the block backs up.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         stall_left <= 0;
         hold_left <= 0;
         hold_done <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_ch.ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (!hold_done && req_beats >= HOLD_AFTER_BEATS) begin
         rsp_ch.ready <= 1'b0;
         hold_left <= HOLD_CYCLES - 1;
         hold_done <= 1'b1;
      end else if (stall_left != 0) begin
         rsp_ch.ready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if ($urandom_range(0, 99) < idle_pct) begin
         rsp_ch.ready <= 1'b0;
         stall_left <= $urandom_range(0, 6);
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   // Response checker: each beat against the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (timer_outcomes.size() == 0) begin
            $error("response beat arrived with no request outstanding");
            errors++;
         end else begin
            oldest = timer_outcomes.pop_front();
            if (rsp_ch.read_data !== oldest.read_data) begin
               $error("read_data: expected %h, got %h", oldest.read_data, rsp_ch.read_data);
               errors++;
            end
            if (rsp_ch.irq_pulse !== oldest.irq_pulse) begin
               $error("irq_pulse: expected %b, got %b", oldest.irq_pulse, rsp_ch.irq_pulse);
               errors++;
            end
            if (rsp_ch.elapsed_ticks !== oldest.elapsed_ticks) begin
               $error("elapsed_ticks: expected %h, got %h", oldest.elapsed_ticks,
                      rsp_ch.elapsed_ticks);
               errors++;
            end
         end
      end
   end

   // Watchdog: ends the run when no beat moves on either channel for too long.
   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("system_tick_timer test failed");
            $finish;
         end
      end
   end

   // Waits until every queued beat has been sent and answered.
   task automatic wait_drained();
      while (bus_requests.size() != 0 || req_ch.valid || timer_outcomes.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_shot_mode(logic mode);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= mode;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      tmr_one_shot = mode;
   endtask

   // One well-formed timer session: program reload and control, then a run of ticks
   // from the selected source with a few stray ticks and reads mixed in.
   task automatic queue_timer_session();
      logic [DATA_W-1:0] ctl;
      logic [DATA_W-1:0] rld;
      int                ticks;
      func_type          own_src;
      func_type          other_src;
      rld = $urandom;
      if ($urandom_range(0, 7) != 0)
         rld[COUNT_W-1:0] = COUNT_W'($urandom_range(0, 6));
      push_req(FUNC_WRITE, REG_RELOAD, rld);
      phase_count++;
      if ($urandom_range(0, 1) == 0) begin
         push_req(FUNC_WRITE, REG_CURRENT, $urandom);
         phase_count++;
      end
      ctl = $urandom;
      ctl[CTRL_EN_BIT] = ($urandom_range(0, 9) != 0);
      push_req(FUNC_WRITE, REG_CONTROL, ctl);
      phase_count++;
      own_src = ctl[CTRL_CLK_BIT] ? FUNC_CORE_TICK : FUNC_REF_TICK;
      other_src = ctl[CTRL_CLK_BIT] ? FUNC_REF_TICK : FUNC_CORE_TICK;
      ticks = $urandom_range(3, 20);
      repeat (ticks) begin
         case ($urandom_range(0, 19))
            0: push_req(other_src, SEL_W'($urandom_range(0, 3)), $urandom);
            1, 2: begin
               push_req(FUNC_READ, SEL_W'($urandom_range(0, 3)), $urandom);
               phase_count++;
            end
            default: begin
               push_req(own_src, SEL_W'($urandom_range(0, 3)), $urandom);
               phase_count++;
            end
         endcase
      end
   endtask

   // Random phase: mostly sessions, the rest unstructured beats.
   task automatic queue_random_phase();
      phase_count = 0;
      while (phase_count < PHASE_ITEMS) begin
         if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 6)) begin
               push_req(func_type'($urandom_range(0, 3)), SEL_W'($urandom_range(0, 3)),
                        $urandom);
               phase_count++;
            end
         end else begin
            queue_timer_session();
         end
      end
   endtask

   // Stimulus and end of run.
   initial begin
      reset <= 1'b1;
      csr_wr_en <= 1'b0;
      csr_wr_data <= 1'b0;
      tmr_one_shot = 1'b1;
      idle_pct = 15;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed: reset values, unused register, truncation, reload from zero,
      // one-shot firing, flag clear on read, firing without interrupt, zero reload.
      push_req(FUNC_READ, REG_CONTROL, '0);
      push_req(FUNC_READ, REG_RELOAD, '0);
      push_req(FUNC_READ, REG_CURRENT, '0);
      push_req(FUNC_READ, REG_UNUSED, '0);
      push_req(FUNC_WRITE, REG_UNUSED, 32'hFFFF_FFFF);
      push_req(FUNC_WRITE, REG_RELOAD, 32'hFFFF_FFFF);
      push_req(FUNC_WRITE, REG_CONTROL, 32'hFFFF_FFFF);
      push_req(FUNC_REF_TICK, REG_CONTROL, '0);
      push_req(FUNC_CORE_TICK, REG_CONTROL, '0);
      push_req(FUNC_CORE_TICK, REG_CONTROL, '0);
      push_req(FUNC_READ, REG_CURRENT, '0);
      push_req(FUNC_WRITE, REG_CURRENT, 32'h5A5A_5A5A);
      push_req(FUNC_WRITE, REG_RELOAD, 32'd2);
      repeat (3) push_req(FUNC_CORE_TICK, REG_CONTROL, '0);
      repeat (2) push_req(FUNC_READ, REG_CONTROL, '0);
      push_req(FUNC_WRITE, REG_CONTROL, 32'd1);
      push_req(FUNC_WRITE, REG_RELOAD, 32'd1);
      repeat (2) push_req(FUNC_REF_TICK, REG_CONTROL, '0);
      push_req(FUNC_READ, REG_CONTROL, '0);
      push_req(FUNC_WRITE, REG_RELOAD, '0);
      push_req(FUNC_WRITE, REG_CURRENT, '0);
      repeat (2) push_req(FUNC_REF_TICK, REG_CONTROL, '0);
      wait_drained();

      // Random phases alternate periodic and one-shot mode; the last runs without idling.
      write_shot_mode(1'b0);
      queue_random_phase();
      wait_drained();
      write_shot_mode(1'b1);
      idle_pct = 30;
      queue_random_phase();
      wait_drained();
      write_shot_mode(1'b0);
      idle_pct = 8;
      queue_random_phase();
      wait_drained();
      write_shot_mode(1'b1);
      idle_pct = 0;
      queue_random_phase();
      wait_drained();

      if (errors == 0) begin
         $display("system_tick_timer test passed");
      end else begin
         $display("system_tick_timer test failed");
      end
      $finish;
   end

endmodule
